### hw/rtl/ppg_pkg.sv
// Shared types, constants and trigonometry helpers for the plasma pixel generator.
// Depends on nothing; every other file in hw/rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package ppg_pkg;

   // Request codes carried on req_type.
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COLOUR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_COLOUR   = 2'd1;

   // Field widths.
   localparam int unsigned COORD_W     = 6;
   localparam int unsigned COLOUR_W    = 24;
   localparam int unsigned CHANNEL_W   = 8;
   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned INDEX_OUT_W = 8;

   // Palette size default.
   localparam int unsigned COLOURS_DEFAULT = 256;

   // Phase counters run over degrees 0..359.
   localparam int unsigned PHASE_W    = 9;
   localparam logic [PHASE_W-1:0] PHASE_LAST   = 9'd359;
   localparam logic [PHASE_W-1:0] PHASE_FULL   = 9'd360;
   localparam logic [PHASE_W-1:0] PHASE_HALF   = 9'd180;
   localparam logic [PHASE_W-1:0] PHASE_3QTR   = 9'd270;
   localparam logic [PHASE_W-1:0] PHASE_QUARTER = 9'd90;

   // Q1.15 trig samples and Q7.16 amplitudes.
   localparam int unsigned TRIG_W = 16;
   localparam int unsigned AMP_W  = 24;
   localparam logic signed [AMP_W-1:0] ROW_AMP_RESET = 24'sd3866624;  // 59.0
   localparam logic signed [AMP_W-1:0] COL_AMP_RESET = 24'sd655360;   // 10.0
   localparam logic signed [AMP_W-1:0] ROW_AMP_BASE  = 24'sd1310720;  // 20.0
   localparam logic signed [AMP_W-1:0] COL_AMP_BASE  = 24'sd655360;   // 10.0
   localparam logic signed [AMP_W-1:0] AMP_GAIN      = 24'sd78;       // 39.0 scaled to Q16/Q15

   // Plasma term arithmetic: Q31 terms, Q16 magnitudes, integer product.
   localparam int unsigned TERM_W     = 42;
   localparam logic signed [TERM_W-1:0] ROW_OFFSET = 42'sd4294967296;  // 2.0 in Q31
   localparam logic signed [TERM_W-1:0] COL_OFFSET = 42'sd6442450944;  // 3.0 in Q31
   localparam int unsigned MAG_SHIFT  = 15;
   localparam int unsigned MAG_W      = 22;
   localparam int unsigned PLASMA_SHIFT = 32;
   localparam int unsigned PLASMA_W   = 12;
   localparam int unsigned MOD_SHIFT  = 2 * PLASMA_W;

   // Quarter-wave sine table, 0..90 degrees.
   localparam int unsigned QTR_DEPTH = 91;
   localparam int unsigned QTR_IDX_W = $clog2(QTR_DEPTH);
   localparam int unsigned QTR_W     = 15;
   localparam logic [63:0] PI_Q30    = 64'd3373259426;

   typedef logic [QTR_W-1:0] quarter_table_type [0:QTR_DEPTH-1];

   typedef struct packed {
      logic [PHASE_W-1:0]      sine_phase;
      logic [PHASE_W-1:0]      cosine_phase;
      logic signed [AMP_W-1:0] row_amplitude;
      logic signed [AMP_W-1:0] column_amplitude;
   } phase_state_type;

   // Taylor series in Q30, rounded to Q15 and clipped below one.
   function automatic quarter_table_type build_quarter_sine();
      quarter_table_type tbl;
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] v;
      for (int d = 0; d < QTR_DEPTH; d++) begin
         x = (64'(d) * PI_Q30) / 64'd180;
         x2 = (x * x) >> 30;
         term = x;
         sum = signed'(x);
         for (int k = 1; k <= 8; k++) begin
            term = (term * x2) >> 30;
            // Each new term is divided by (2k)(2k+1).
            case (k)
               1:       term = term / 64'd6;
               2:       term = term / 64'd20;
               3:       term = term / 64'd42;
               4:       term = term / 64'd72;
               5:       term = term / 64'd110;
               6:       term = term / 64'd156;
               7:       term = term / 64'd210;
               default: term = term / 64'd272;
            endcase
            if ((k & 1) != 0) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         v = (sum + 64'sd16384) >>> 15;
         if (v > 64'sd32767) begin
            v = 64'sd32767;
         end
         tbl[d] = v[QTR_W-1:0];
      end
      return tbl;
   endfunction

   localparam quarter_table_type QUARTER_SINE = build_quarter_sine();

   // Sine of an angle in 0..359 degrees, Q1.15, folded onto the quarter table.
   function automatic logic signed [TRIG_W-1:0] sine_q15(input logic [PHASE_W-1:0] deg);
      logic [QTR_IDX_W-1:0] idx;
      logic                 neg;
      logic signed [TRIG_W-1:0] mag;
      if (deg <= PHASE_QUARTER) begin
         idx = QTR_IDX_W'(deg);
         neg = 1'b0;
      end else if (deg <= PHASE_HALF) begin
         idx = QTR_IDX_W'(PHASE_HALF - deg);
         neg = 1'b0;
      end else if (deg <= PHASE_3QTR) begin
         idx = QTR_IDX_W'(deg - PHASE_HALF);
         neg = 1'b1;
      end else begin
         idx = QTR_IDX_W'(PHASE_FULL - deg);
         neg = 1'b1;
      end
      mag = signed'({1'b0, QUARTER_SINE[idx]});
      return neg ? -mag : mag;
   endfunction

   // Cosine as the sine a quarter turn ahead.
   function automatic logic signed [TRIG_W-1:0] cosine_q15(input logic [PHASE_W-1:0] deg);
      logic [PHASE_W-1:0] ahead;
      ahead = (deg >= PHASE_3QTR) ? (deg - PHASE_3QTR) : (deg + PHASE_QUARTER);
      return sine_q15(ahead);
   endfunction

endpackage

`default_nettype wire

### hw/rtl/plasma_pixel_generator.sv
// Top level of the plasma pixel generator: colour registers, animation state
// and the two pipelines. Depends on ppg_pkg, ppg_phase, ppg_wave and ppg_ramp.
//
//   Channel   Direction   Handshake            Word
//   req_      in          req_valid/req_stall  req_type, req_pixel_x, req_pixel_y
//   rsp_      out         rsp_valid/rsp_stall  rsp_red, rsp_green, rsp_blue, rsp_colour_index
//   csr_      in          csr_wr_en            csr_index, csr_wdata
//
// One word is accepted per cycle while req_stall is low. A tick updates the phase
// and amplitude registers at once; it produces no result. A pixel word passes
// through the five plasma stages and the five palette stages before it leaves
// on rsp_. Reset is synchronous and needs no clearing pass. Empty stages are
// squeezed out under rsp_stall; req_stall rises only when every stage holds a
// word.
`timescale 1ns / 1ps
`default_nettype none

module plasma_pixel_generator #(
   parameter int unsigned COLOURS = ppg_pkg::COLOURS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_type,
   input  logic [ppg_pkg::COORD_W-1:0]      req_pixel_x,
   input  logic [ppg_pkg::COORD_W-1:0]      req_pixel_y,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [ppg_pkg::CHANNEL_W-1:0]    rsp_red,
   output logic [ppg_pkg::CHANNEL_W-1:0]    rsp_green,
   output logic [ppg_pkg::CHANNEL_W-1:0]    rsp_blue,
   output logic [ppg_pkg::INDEX_OUT_W-1:0]  rsp_colour_index,
   input  logic                             csr_wr_en,
   input  logic [ppg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ppg_pkg::COLOUR_W-1:0]     csr_wdata
);
   import ppg_pkg::*;

   logic [COLOUR_W-1:0] start_colour_ff;
   logic [COLOUR_W-1:0] end_colour_ff;
   phase_state_type     phase_state;
   logic                wave_in_ready;
   logic                tick;
   logic                pixel_valid;
   logic                wave_valid;
   logic                ramp_in_ready;
   logic [PLASMA_W-1:0] wave_plasma;

   // Colour registers; writes to unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_colour_ff <= '0;
         end_colour_ff   <= '1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_START_COLOUR: start_colour_ff <= csr_wdata;
            CSR_END_COLOUR:   end_colour_ff   <= csr_wdata;
            default:          ;
         endcase
      end
   end

   // Request steering: ticks go to the phase state, pixels into the pipeline.
   assign req_stall   = !wave_in_ready;
   assign tick        = req_valid && !req_stall && (req_type == REQ_TICK);
   assign pixel_valid = req_valid && (req_type == REQ_PIXEL);

   ppg_phase u_phase (
      .clock       (clock),
      .reset       (reset),
      .tick        (tick),
      .phase_state (phase_state)
   );

   ppg_wave u_wave (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (pixel_valid),
      .in_ready    (wave_in_ready),
      .pixel_x     (req_pixel_x),
      .pixel_y     (req_pixel_y),
      .phase_state (phase_state),
      .out_valid   (wave_valid),
      .out_ready   (ramp_in_ready),
      .out_plasma  (wave_plasma)
   );

   ppg_ramp #(
      .COLOURS (COLOURS)
   ) u_ramp (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (wave_valid),
      .in_ready         (ramp_in_ready),
      .in_plasma        (wave_plasma),
      .start_colour     (start_colour_ff),
      .end_colour       (end_colour_ff),
      .out_valid        (rsp_valid),
      .out_ready        (!rsp_stall),
      .out_red          (rsp_red),
      .out_green        (rsp_green),
      .out_blue         (rsp_blue),
      .out_colour_index (rsp_colour_index)
   );

endmodule

`default_nettype wire

### hw/rtl/ppg_phase.sv
// Animation state: the two degree counters and the two Q7.16 amplitudes.
// Depends on ppg_pkg for the trig helpers and state type.
`timescale 1ns / 1ps
`default_nettype none

module ppg_phase (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     tick,
   output ppg_pkg::phase_state_type phase_state
);
   import ppg_pkg::*;

   logic [PHASE_W-1:0]      sine_phase_ff, sine_phase_in;
   logic [PHASE_W-1:0]      cosine_phase_ff, cosine_phase_in;
   logic signed [AMP_W-1:0] row_amp_ff, row_amp_in;
   logic signed [AMP_W-1:0] col_amp_ff, col_amp_in;

   // Advance both counters by one degree and rescale the amplitudes.
   always_comb begin
      sine_phase_in   = (sine_phase_ff == PHASE_LAST) ? '0 : sine_phase_ff + 1'b1;
      cosine_phase_in = (cosine_phase_ff == PHASE_LAST) ? '0 : cosine_phase_ff + 1'b1;
      row_amp_in = ROW_AMP_BASE + AMP_W'(cosine_q15(cosine_phase_in)) * AMP_GAIN;
      col_amp_in = COL_AMP_BASE + AMP_W'(sine_q15(sine_phase_in)) * AMP_GAIN;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_phase_ff   <= '0;
         cosine_phase_ff <= '0;
         row_amp_ff      <= ROW_AMP_RESET;
         col_amp_ff      <= COL_AMP_RESET;
      end else if (tick) begin
         sine_phase_ff   <= sine_phase_in;
         cosine_phase_ff <= cosine_phase_in;
         row_amp_ff      <= row_amp_in;
         col_amp_ff      <= col_amp_in;
      end
   end

   assign phase_state.sine_phase       = sine_phase_ff;
   assign phase_state.cosine_phase     = cosine_phase_ff;
   assign phase_state.row_amplitude    = row_amp_ff;
   assign phase_state.column_amplitude = col_amp_ff;

endmodule

`default_nettype wire

### hw/rtl/ppg_wave.sv
// Five-stage plasma function pipeline: table angles, trig lookup, scaled terms,
// Q16 magnitudes and their integer product. Depends on ppg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppg_wave (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [ppg_pkg::COORD_W-1:0]    pixel_x,
   input  logic [ppg_pkg::COORD_W-1:0]    pixel_y,
   input  ppg_pkg::phase_state_type       phase_state,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [ppg_pkg::PLASMA_W-1:0]   out_plasma
);
   import ppg_pkg::*;

   localparam int unsigned STAGES = 5;
   localparam int unsigned SUM_W  = PHASE_W + 1;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_ready;
   logic [STAGES-1:0] load;

   // Stage 1: table angles and amplitude snapshot.
   logic [PHASE_W-1:0]      sin_angle_ff, sin_angle_in;
   logic [PHASE_W-1:0]      cos_angle_ff, cos_angle_in;
   logic signed [AMP_W-1:0] row_amp1_ff, col_amp1_ff;
   logic [SUM_W-1:0]        sin_sum, cos_sum;
   // Stage 2: trig samples.
   logic signed [TRIG_W-1:0] sin_ff, sin_in;
   logic signed [TRIG_W-1:0] cos_ff, cos_in;
   logic signed [AMP_W-1:0]  row_amp2_ff, col_amp2_ff;
   // Stage 3: Q31 terms.
   logic signed [TERM_W-1:0] row_term_ff, row_term_in;
   logic signed [TERM_W-1:0] col_term_ff, col_term_in;
   // Stage 4: Q16 magnitudes.
   logic [MAG_W-1:0] row_mag_ff, row_mag_in;
   logic [MAG_W-1:0] col_mag_ff, col_mag_in;
   logic [TERM_W-1:0] row_abs, col_abs;
   // Stage 5: integer plasma value.
   logic [PLASMA_W-1:0]      plasma_ff, plasma_in;
   logic [2*MAG_W-1:0]       mag_product;

   // Each stage moves on when it is empty or the stage after it moves.
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};
   assign load     = stage_ready & valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Angles wrap modulo 360; the cosine angle already carries its quarter turn.
   always_comb begin
      sin_sum = SUM_W'(phase_state.sine_phase) + SUM_W'(pixel_y);
      cos_sum = SUM_W'(phase_state.cosine_phase) + SUM_W'(pixel_x) + SUM_W'(PHASE_QUARTER);
      sin_angle_in = (sin_sum >= SUM_W'(PHASE_FULL)) ? PHASE_W'(sin_sum - SUM_W'(PHASE_FULL))
                                                     : PHASE_W'(sin_sum);
      cos_angle_in = (cos_sum >= SUM_W'(PHASE_FULL)) ? PHASE_W'(cos_sum - SUM_W'(PHASE_FULL))
                                                     : PHASE_W'(cos_sum);
   end

   // Trig lookup from the quarter table.
   always_comb begin
      sin_in = sine_q15(sin_angle_ff);
      cos_in = sine_q15(cos_angle_ff);
   end

   // Amplitude times sample plus the constant offset, all in Q31.
   always_comb begin
      row_term_in = TERM_W'(row_amp2_ff) * TERM_W'(sin_ff) + ROW_OFFSET;
      col_term_in = TERM_W'(col_amp2_ff) * TERM_W'(cos_ff) + COL_OFFSET;
   end

   // Absolute value truncated to Q16.
   always_comb begin
      row_abs = row_term_ff[TERM_W-1] ? TERM_W'(-row_term_ff) : TERM_W'(row_term_ff);
      col_abs = col_term_ff[TERM_W-1] ? TERM_W'(-col_term_ff) : TERM_W'(col_term_ff);
      row_mag_in = row_abs[MAG_SHIFT +: MAG_W];
      col_mag_in = col_abs[MAG_SHIFT +: MAG_W];
   end

   // Product of the two Q16 magnitudes, integer part.
   always_comb begin
      mag_product = (2*MAG_W)'(row_mag_ff) * (2*MAG_W)'(col_mag_ff);
      plasma_in   = mag_product[PLASMA_SHIFT +: PLASMA_W];
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         sin_angle_ff <= sin_angle_in;
         cos_angle_ff <= cos_angle_in;
         row_amp1_ff  <= phase_state.row_amplitude;
         col_amp1_ff  <= phase_state.column_amplitude;
      end
      if (load[1]) begin
         sin_ff      <= sin_in;
         cos_ff      <= cos_in;
         row_amp2_ff <= row_amp1_ff;
         col_amp2_ff <= col_amp1_ff;
      end
      if (load[2]) begin
         row_term_ff <= row_term_in;
         col_term_ff <= col_term_in;
      end
      if (load[3]) begin
         row_mag_ff <= row_mag_in;
         col_mag_ff <= col_mag_in;
      end
      if (load[4]) begin
         plasma_ff <= plasma_in;
      end
   end

   assign in_ready   = stage_ready[0];
   assign out_valid  = valid_ff[STAGES-1];
   assign out_plasma = plasma_ff;

endmodule

`default_nettype wire

### hw/rtl/ppg_ramp.sv
// Five-stage palette pipeline: modulo reduction, ramp position, channel blend
// and division by the half palette; the last stage is the result register.
// Depends on ppg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ppg_ramp #(
   parameter int unsigned COLOURS = ppg_pkg::COLOURS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [ppg_pkg::PLASMA_W-1:0]    in_plasma,
   input  logic [ppg_pkg::COLOUR_W-1:0]    start_colour,
   input  logic [ppg_pkg::COLOUR_W-1:0]    end_colour,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [ppg_pkg::CHANNEL_W-1:0]   out_red,
   output logic [ppg_pkg::CHANNEL_W-1:0]   out_green,
   output logic [ppg_pkg::CHANNEL_W-1:0]   out_blue,
   output logic [ppg_pkg::INDEX_OUT_W-1:0] out_colour_index
);
   import ppg_pkg::*;

   localparam int unsigned STAGES = 5;

   // Modulo by reciprocal: exact for every plasma value below 2^PLASMA_W.
   localparam longint unsigned MOD_RECIP =
      ((64'd1 << MOD_SHIFT) + 64'(COLOURS) - 64'd1) / 64'(COLOURS);
   localparam int unsigned MOD_PROD_W = PLASMA_W + MOD_SHIFT;
   localparam int unsigned IDX_W      = $clog2(COLOURS);

   // Ramp position and division by the half palette, also by reciprocal.
   localparam int unsigned HALF       = COLOURS / 2;
   localparam int unsigned K_W        = $clog2(HALF + 1);
   localparam int unsigned NUM_W      = CHANNEL_W + K_W;
   localparam int unsigned DIV_SHIFT  = 2 * CHANNEL_W - 7 + 2 * $clog2(HALF);
   localparam int unsigned DIV_RECIP_W = DIV_SHIFT - $clog2(HALF) + 2;
   localparam longint unsigned DIV_RECIP =
      ((64'd1 << DIV_SHIFT) + 64'(HALF) - 64'd1) / 64'(HALF);
   localparam int unsigned DIV_PROD_W = NUM_W + DIV_RECIP_W;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_ready;
   logic [STAGES-1:0] load;

   // Stage 1: quotient estimate.
   logic [MOD_PROD_W-1:0] mod_product;
   logic [PLASMA_W-1:0]   quot_ff, quot_in;
   logic [PLASMA_W-1:0]   plasma1_ff;
   // Stage 2: palette index.
   logic [PLASMA_W-1:0]   rem;
   logic [IDX_W-1:0]      index2_ff, index2_in;
   // Stage 3: ramp weights.
   logic [K_W-1:0]         up_ff, up_in;
   logic [K_W-1:0]         down_ff, down_in;
   logic [INDEX_OUT_W-1:0] index3_ff;
   // Stage 4: blended numerators.
   logic [CHANNEL_W-1:0]   start_ch [NUM_CHANNELS];
   logic [CHANNEL_W-1:0]   end_ch   [NUM_CHANNELS];
   logic [NUM_W-1:0]       num_ff   [NUM_CHANNELS];
   logic [NUM_W-1:0]       num_in   [NUM_CHANNELS];
   logic [INDEX_OUT_W-1:0] index4_ff;
   // Stage 5: result word.
   logic [DIV_PROD_W-1:0]  div_product [NUM_CHANNELS];
   logic [CHANNEL_W-1:0]   chan_ff [NUM_CHANNELS];
   logic [CHANNEL_W-1:0]   chan_in [NUM_CHANNELS];
   logic [INDEX_OUT_W-1:0] index5_ff;

   // Each stage moves on when it is empty or the stage after it moves.
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   assign valid_in = {valid_ff[STAGES-2:0], in_valid};
   assign load     = stage_ready & valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < STAGES; s++) begin
            if (stage_ready[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Quotient of the plasma value by the palette size.
   always_comb begin
      mod_product = MOD_PROD_W'(in_plasma) * MOD_PROD_W'(MOD_RECIP);
      quot_in     = mod_product[MOD_SHIFT +: PLASMA_W];
   end

   // Remainder, with one corrective subtract.
   always_comb begin
      rem = PLASMA_W'(plasma1_ff - PLASMA_W'(quot_ff * COLOURS));
      if ((PLASMA_W + 1)'(rem) >= (PLASMA_W + 1)'(COLOURS)) begin
         rem = PLASMA_W'(rem - PLASMA_W'(COLOURS));
      end
      index2_in = IDX_W'(rem);
   end

   // Triangular ramp: rises over the lower half, falls over the upper half.
   always_comb begin
      if (index2_ff < IDX_W'(HALF)) begin
         up_in = K_W'(index2_ff + 1);
      end else begin
         up_in = K_W'(COLOURS - 1 - index2_ff);
      end
      down_in = K_W'(HALF) - up_in;
   end

   // Weighted sum of start and end colours per channel, red first.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         start_ch[c] = start_colour[(NUM_CHANNELS - 1 - c) * CHANNEL_W +: CHANNEL_W];
         end_ch[c]   = end_colour[(NUM_CHANNELS - 1 - c) * CHANNEL_W +: CHANNEL_W];
         num_in[c]   = NUM_W'(start_ch[c]) * NUM_W'(down_ff)
                     + NUM_W'(end_ch[c]) * NUM_W'(up_ff);
      end
   end

   // Division by the half palette.
   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         div_product[c] = DIV_PROD_W'(num_ff[c]) * DIV_PROD_W'(DIV_RECIP);
         chan_in[c]     = div_product[c][DIV_SHIFT +: CHANNEL_W];
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         quot_ff    <= quot_in;
         plasma1_ff <= in_plasma;
      end
      if (load[1]) begin
         index2_ff <= index2_in;
      end
      if (load[2]) begin
         up_ff     <= up_in;
         down_ff   <= down_in;
         index3_ff <= INDEX_OUT_W'(index2_ff);
      end
      if (load[3]) begin
         num_ff    <= num_in;
         index4_ff <= index3_ff;
      end
      if (load[4]) begin
         chan_ff   <= chan_in;
         index5_ff <= index4_ff;
      end
   end

   assign in_ready         = stage_ready[0];
   assign out_valid        = valid_ff[STAGES-1];
   assign out_red          = chan_ff[0];
   assign out_green        = chan_ff[1];
   assign out_blue         = chan_ff[2];
   assign out_colour_index = index5_ff;

endmodule

`default_nettype wire
